// ===== rtl/core/kthm_pkg.sv =====
// ---------------------------------------------------------------------------
// kthm_pkg
// Shared types and constants for the key to handle map table.
// ---------------------------------------------------------------------------
`default_nettype none

package kthm_pkg;

   localparam int KEY_W               = 16;
   localparam int HANDLE_W            = 16;
   localparam int DEFAULT_TABLE_DEPTH = 8;

   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_LOOKUP = 2'd1,
      ACT_REMOVE = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_NOT_FOUND = 2'd1,
      STS_FULL      = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/core/kthm_ram.sv =====
// ---------------------------------------------------------------------------
// kthm_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module kthm_ram #(
   parameter int WIDTH = kthm_pkg::KEY_W,
   parameter int DEPTH = kthm_pkg::DEFAULT_TABLE_DEPTH,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/key_to_handle_map_table.sv =====
// ---------------------------------------------------------------------------
// key_to_handle_map_table
// Associative table of nonzero 16-bit keys mapped to 16-bit device handles.
// ---------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Keys and handles
// live in two RAMs that are scanned one slot per cycle from slot 0; the scan
// stops at the first slot whose key matches (the empty key for an add), or
// after the last slot. Busy stays high from acceptance until the scan ends; a
// key of zero or an unused action skips the scan and leaves busy low.
// The result appears on rsp_* for one cycle with rsp_valid high, the cycle
// after the scan ends; the receiver cannot stall it. After reset the block
// clears every slot of both RAMs, holding busy high until the pass is done.
// ---------------------------------------------------------------------------
`default_nettype none

module key_to_handle_map_table #(
   parameter int TABLE_DEPTH = kthm_pkg::DEFAULT_TABLE_DEPTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [1:0]                    req_action,
   input  wire logic [kthm_pkg::KEY_W-1:0]    req_key,
   input  wire logic [kthm_pkg::HANDLE_W-1:0] req_handle_in,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_status,
   output logic [kthm_pkg::HANDLE_W-1:0]      rsp_handle_out
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   kthm_pkg::state_type  state_ff, state_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   kthm_pkg::action_type act_ff, act_in;
   logic [kthm_pkg::KEY_W-1:0]    key_ff, key_in;
   logic [kthm_pkg::HANDLE_W-1:0] handle_ff, handle_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   kthm_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic [kthm_pkg::HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;

   logic                          mem_we;
   logic [IDX_W-1:0]              mem_waddr;
   logic [kthm_pkg::KEY_W-1:0]    mem_wkey;
   logic [kthm_pkg::HANDLE_W-1:0] mem_whandle;
   logic                          mem_re;
   logic [IDX_W-1:0]              mem_raddr;
   logic [kthm_pkg::KEY_W-1:0]    rd_key;
   logic [kthm_pkg::HANDLE_W-1:0] rd_handle;
   logic [kthm_pkg::KEY_W-1:0]    target;
   logic                          hit;
   kthm_pkg::action_type          req_act;

   kthm_ram #(.WIDTH(kthm_pkg::KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wkey),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (rd_key)
   );

   kthm_ram #(.WIDTH(kthm_pkg::HANDLE_W), .DEPTH(TABLE_DEPTH)) u_handle_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_whandle),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (rd_handle)
   );

   assign req_act = kthm_pkg::action_type'(req_action);
   assign target  = (act_ff == kthm_pkg::ACT_ADD) ? '0 : key_ff;
   assign hit     = (rd_key == target);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kthm_pkg::ST_CLEAR;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      key_ff        <= key_in;
      handle_ff     <= handle_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      act_in        = act_ff;
      key_in        = key_ff;
      handle_in     = handle_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff;
      mem_wkey      = '0;
      mem_whandle   = '0;
      mem_re        = 1'b0;
      mem_raddr     = IDX_W'(idx_ff + 1'b1);
      busy          = 1'b1;

      case (state_ff)
         kthm_pkg::ST_CLEAR: begin
            mem_we = 1'b1;
            idx_in = IDX_W'(idx_ff + 1'b1);
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = kthm_pkg::ST_IDLE;
            end
         end

         kthm_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               act_in        = req_act;
               key_in        = req_key;
               handle_in     = req_handle_in;
               rsp_status_in = kthm_pkg::STS_OK;
               rsp_handle_in = '0;
               if (req_key != '0 && (req_act == kthm_pkg::ACT_ADD ||
                   req_act == kthm_pkg::ACT_LOOKUP || req_act == kthm_pkg::ACT_REMOVE)) begin
                  mem_re    = 1'b1;
                  mem_raddr = '0;
                  idx_in    = '0;
                  state_in  = kthm_pkg::ST_SCAN;
               end else begin
                  rsp_valid_in = 1'b1;
                  if (req_act == kthm_pkg::ACT_LOOKUP) begin
                     rsp_status_in = kthm_pkg::STS_NOT_FOUND;
                  end
               end
            end
         end

         kthm_pkg::ST_SCAN: begin
            if (hit) begin
               rsp_valid_in = 1'b1;
               state_in     = kthm_pkg::ST_IDLE;
               case (act_ff)
                  kthm_pkg::ACT_ADD: begin
                     mem_we      = 1'b1;
                     mem_wkey    = key_ff;
                     mem_whandle = handle_ff;
                  end
                  kthm_pkg::ACT_LOOKUP: begin
                     rsp_handle_in = rd_handle;
                  end
                  kthm_pkg::ACT_REMOVE: begin
                     mem_we = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end else if (idx_ff == LAST_IDX) begin
               rsp_valid_in = 1'b1;
               state_in     = kthm_pkg::ST_IDLE;
               case (act_ff)
                  kthm_pkg::ACT_ADD:    rsp_status_in = kthm_pkg::STS_FULL;
                  kthm_pkg::ACT_LOOKUP: rsp_status_in = kthm_pkg::STS_NOT_FOUND;
                  default:              rsp_status_in = kthm_pkg::STS_OK;
               endcase
            end else begin
               mem_re = 1'b1;
               idx_in = IDX_W'(idx_ff + 1'b1);
            end
         end

         default: begin
            state_in = kthm_pkg::ST_CLEAR;
            idx_in   = '0;
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_handle_out = rsp_handle_ff;

   a_clear_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == kthm_pkg::ST_CLEAR) |=> !rsp_valid)
      else $error("result issued during clearing pass");

   a_handle_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != kthm_pkg::STS_OK) |-> (rsp_handle_out == '0))
      else $error("nonzero handle with failing status");

   a_write_only_busy: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> busy)
      else $error("table write while idle");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// ---------------------------------------------------------------------------
// key_to_handle_map_table testbench
// Drives add, lookup, remove and unused-action transactions through the start/busy command
// port, keeps a shadow copy of the key and handle slots to predict each
// response, and checks every rsp_valid strobe against the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   localparam int DEPTH = kthm_pkg::DEFAULT_TABLE_DEPTH;
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam logic [kthm_pkg::KEY_W-1:0] EMPTY_KEY = '0;
   localparam int STALL_LIMIT = 2000;
   localparam int POOL_SIZE = 12;

   typedef struct packed {
      kthm_pkg::status_type            status;
      logic [kthm_pkg::HANDLE_W-1:0]   handle;
   } table_reply_type;

   logic                            clock;
   logic                            reset;
   logic                            start;
   logic                            busy;
   logic [1:0]                      req_action;
   logic [kthm_pkg::KEY_W-1:0]      req_key;
   logic [kthm_pkg::HANDLE_W-1:0]   req_handle_in;
   logic                            rsp_valid;
   logic [1:0]                      rsp_status;
   logic [kthm_pkg::HANDLE_W-1:0]   rsp_handle_out;

   logic [kthm_pkg::KEY_W-1:0]      shadow_keys [DEPTH];
   logic [kthm_pkg::HANDLE_W-1:0]   shadow_handles [DEPTH];
   table_reply_type                 pending_replies [$];
   table_reply_type                 reply_next;
   table_reply_type                 reply_seen;
   logic [kthm_pkg::KEY_W-1:0]      key_pool [POOL_SIZE];
   int                              idle_pct;
   int                              fail_count;
   int                              quiet_cycles;

   key_to_handle_map_table #(.TABLE_DEPTH(DEPTH)) u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_key        (req_key),
      .req_handle_in  (req_handle_in),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_handle_out (rsp_handle_out)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int first_slot_with(logic [kthm_pkg::KEY_W-1:0] key);
      for (int i = 0; i < DEPTH; i++)
         if (shadow_keys[i] == key)
            return i;
      return DEPTH;
   endfunction

   function automatic table_reply_type apply_table_op(
         logic [1:0] action,
         logic [kthm_pkg::KEY_W-1:0] key,
         logic [kthm_pkg::HANDLE_W-1:0] handle);
      table_reply_type reply;
      int              slot;
      reply.status = kthm_pkg::STS_OK;
      reply.handle = '0;
      case (action)
         kthm_pkg::ACT_ADD: begin
            if (key != EMPTY_KEY) begin
               slot = first_slot_with(EMPTY_KEY);
               if (slot < DEPTH) begin
                  shadow_keys[slot]    = key;
                  shadow_handles[slot] = handle;
               end else
                  reply.status = kthm_pkg::STS_FULL;
            end
         end
         kthm_pkg::ACT_LOOKUP: begin
            slot = (key != EMPTY_KEY) ? first_slot_with(key) : DEPTH;
            if (slot < DEPTH)
               reply.handle = shadow_handles[slot];
            else
               reply.status = kthm_pkg::STS_NOT_FOUND;
         end
         kthm_pkg::ACT_REMOVE: begin
            if (key != EMPTY_KEY) begin
               slot = first_slot_with(key);
               if (slot < DEPTH) begin
                  shadow_keys[slot]    = '0;
                  shadow_handles[slot] = '0;
               end
            end
         end
         default: ;
      endcase
      return reply;
   endfunction

   // prediction at acceptance
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            shadow_keys[i]    = '0;
            shadow_handles[i] = '0;
         end
      end else if (start && !busy) begin
         reply_next = apply_table_op(req_action, req_key, req_handle_in);
         pending_replies.push_back(reply_next);
      end
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_replies.size() == 0) begin
            $error("unexpected response: status %0d handle %0h", rsp_status,
                   rsp_handle_out);
            fail_count++;
         end else begin
            reply_seen = pending_replies.pop_front();
            if (rsp_status !== reply_seen.status) begin
               $error("rsp_status: expected %0d, got %0d", reply_seen.status,
                      rsp_status);
               fail_count++;
            end
            if (rsp_handle_out !== reply_seen.handle) begin
               $error("rsp_handle_out: expected %0h, got %0h", reply_seen.handle,
                      rsp_handle_out);
               fail_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         quiet_cycles <= 0;
      else if (quiet_cycles >= STALL_LIMIT) begin
         $display("key_to_handle_map_table regression: fail");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   task automatic send_op(input logic [1:0] action,
                          input logic [kthm_pkg::KEY_W-1:0] key,
                          input logic [kthm_pkg::HANDLE_W-1:0] handle);
      req_action    <= action;
      req_key       <= key;
      req_handle_in <= handle;
      start         <= 1'b1;
      do @(posedge clock); while (busy);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic test_directed_cases();
      idle_pct = 0;
      send_op(kthm_pkg::ACT_ADD, 16'h0001, 16'h0000);
      send_op(kthm_pkg::ACT_ADD, 16'hFFFF, 16'hFFFF);
      send_op(kthm_pkg::ACT_LOOKUP, 16'h0001, 16'h5A5A);
      send_op(kthm_pkg::ACT_LOOKUP, 16'hFFFF, 16'h0000);
      send_op(kthm_pkg::ACT_LOOKUP, 16'h0000, 16'h0000);
      send_op(kthm_pkg::ACT_ADD, 16'h0000, 16'h1234);
      send_op(kthm_pkg::ACT_REMOVE, 16'h0000, 16'h0000);
      send_op(kthm_pkg::ACT_REMOVE, 16'h5555, 16'h0000);
      send_op(kthm_pkg::ACT_ADD, 16'h00AA, 16'h1111);
      send_op(kthm_pkg::ACT_ADD, 16'h00AA, 16'h2222);
      send_op(kthm_pkg::ACT_LOOKUP, 16'h00AA, 16'h0000);
      send_op(kthm_pkg::ACT_REMOVE, 16'h00AA, 16'hFFFF);
      send_op(kthm_pkg::ACT_LOOKUP, 16'h00AA, 16'h0000);
      send_op(ACT_UNUSED, 16'h0001, 16'hFFFF);
      for (int i = 0; i < 5; i++)
         send_op(kthm_pkg::ACT_ADD, 16'h0100 + 16'(i), 16'hC000 + 16'(i));
      send_op(kthm_pkg::ACT_ADD, 16'h7777, 16'h7777);
      send_op(kthm_pkg::ACT_LOOKUP, 16'h7777, 16'h0000);
      send_op(kthm_pkg::ACT_REMOVE, 16'h0001, 16'h0000);
      send_op(kthm_pkg::ACT_ADD, 16'h8000, 16'hA5A5);
      send_op(kthm_pkg::ACT_LOOKUP, 16'h8000, 16'h0000);
   endtask

   task automatic random_ops(input int count);
      int                         pick;
      logic [1:0]                 action;
      logic [kthm_pkg::KEY_W-1:0] key;
      for (int i = 0; i < POOL_SIZE; i++)
         key_pool[i] = 16'($urandom_range(1, 16'hFFFF));
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 40)
            action = kthm_pkg::ACT_ADD;
         else if (pick < 70)
            action = kthm_pkg::ACT_LOOKUP;
         else if (pick < 95)
            action = kthm_pkg::ACT_REMOVE;
         else
            action = ACT_UNUSED;
         pick = $urandom_range(99);
         if (pick < 75)
            key = key_pool[$urandom_range(POOL_SIZE - 1)];
         else if (pick < 90)
            key = 16'($urandom);
         else if (pick < 95)
            key = EMPTY_KEY;
         else
            key = 16'hFFFF;
         send_op(action, key, 16'($urandom));
      end
   endtask

   task automatic test_back_to_back();
      idle_pct = 0;
      random_ops(500);
   endtask

   task automatic test_sparse_requests();
      idle_pct = 83;
      random_ops(500);
   endtask

   task automatic test_light_idling();
      idle_pct = 6;
      random_ops(500);
   endtask

   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_action    = kthm_pkg::ACT_ADD;
      req_key       = '0;
      req_handle_in = '0;
      fail_count    = 0;
      quiet_cycles  = 0;
      idle_pct      = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_back_to_back();
      test_sparse_requests();
      test_light_idling();
      start <= 1'b0;
      while (pending_replies.size() != 0)
         @(posedge clock);
      repeat (DEPTH + 4) @(posedge clock);
      if (fail_count == 0 && pending_replies.size() == 0)
         $display("key_to_handle_map_table regression: pass");
      else
         $display("key_to_handle_map_table regression: fail");
      $finish;
   end

endmodule
